// ===== rtl/hms_pkg.sv =====
// ----------------------------------------------------------------------------
// hms_pkg
// Shared types, codes and reset constants of the hysteretic mode selector.
// ----------------------------------------------------------------------------
`default_nettype none

package hms_pkg;

    localparam int WINDOW_MAX_DEF = 32;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [5:0]  RST_WINDOW_FRAMES     = 6'd5;
    localparam logic [5:0]  RST_REQUIRED_FRAMES   = 6'd3;
    localparam logic [15:0] RST_EXIT_CLEAR_FRAMES = 16'd5;
    localparam logic [23:0] RST_MIN_HOLD_MS       = 24'd2000;
    localparam logic [23:0] RST_COOLDOWN_MS       = 24'd1000;

    typedef enum logic [2:0] {
        FUNC_EVIDENCE = 3'd0,
        FUNC_GUARDED  = 3'd1,
        FUNC_FORCED   = 3'd2,
        FUNC_FALLBACK = 3'd3,
        FUNC_RESTART  = 3'd4
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_FRAMES     = 3'd0,
        CFG_REQUIRED_FRAMES   = 3'd1,
        CFG_EXIT_CLEAR_FRAMES = 3'd2,
        CFG_MIN_HOLD_MS       = 3'd3,
        CFG_COOLDOWN_MS       = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        hold_met;
        logic        cool_over;
        logic [31:0] cool_end_nxt;
    } t_time_st;

endpackage

`default_nettype wire

// ===== rtl/hms_vote.sv =====
// ----------------------------------------------------------------------------
// hms_vote
// Entry vote: shifts one evidence frame into the window, tracks the fill and
// counts positives with an adder tree against the required count.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_vote #(
    parameter int WINDOW_MAX = hms_pkg::WINDOW_MAX_DEF
) (
    input  wire logic [WINDOW_MAX-1:0]            i_hist,
    input  wire logic [$clog2(WINDOW_MAX+1)-1:0]  i_fill,
    input  wire logic [5:0]                       i_win_cfg,
    input  wire logic [5:0]                       i_req,
    input  wire logic                             i_obst,
    output logic      [WINDOW_MAX-1:0]            o_hist_nxt,
    output logic      [$clog2(WINDOW_MAX+1)-1:0]  o_fill_nxt,
    output logic                                  o_pass
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int CMP_W  = (FILL_W > 6) ? FILL_W : 6;
    localparam int LV     = $clog2(WINDOW_MAX);
    localparam int P      = 1 << LV;

    logic [CMP_W-1:0]      win;
    logic [CMP_W-1:0]      cfg_ext;
    logic [WINDOW_MAX-1:0] mask;
    logic [WINDOW_MAX:0]   shifted;
    logic [CMP_W:0]        fill_inc;
    logic [FILL_W-1:0]     lvl [0:LV][0:P-1];

    // clamp the window to 1..WINDOW_MAX
    assign cfg_ext = CMP_W'(i_win_cfg);
    always_comb begin
        if (cfg_ext == '0) begin
            win = CMP_W'(1);
        end else if (cfg_ext > CMP_W'(WINDOW_MAX)) begin
            win = CMP_W'(WINDOW_MAX);
        end else begin
            win = cfg_ext;
        end
    end

    always_comb begin
        for (int i = 0; i < WINDOW_MAX; i++) begin
            mask[i] = (CMP_W'(i) < win);
        end
    end

    // newest frame in bit 0, drop bits beyond the window
    assign shifted    = {i_hist, i_obst};
    assign o_hist_nxt = shifted[WINDOW_MAX-1:0] & mask;

    assign fill_inc = (CMP_W+1)'(i_fill) + (CMP_W+1)'(1);
    assign o_fill_nxt = (fill_inc > (CMP_W+1)'(win)) ? FILL_W'(win) : FILL_W'(fill_inc);

    // population count as a balanced adder tree
    always_comb begin
        for (int j = 0; j < P; j++) begin
            lvl[0][j] = (j < WINDOW_MAX) ? FILL_W'(o_hist_nxt[j]) : '0;
        end
        for (int l = 0; l < LV; l++) begin
            for (int j = 0; j < P; j++) begin
                if (j < (P >> (l + 1))) begin
                    lvl[l+1][j] = lvl[l][2*j] + lvl[l][2*j+1];
                end else begin
                    lvl[l+1][j] = '0;
                end
            end
        end
    end

    assign o_pass = (CMP_W'(o_fill_nxt) == win) && (CMP_W'(lvl[LV][0]) >= CMP_W'(i_req));

endmodule

`default_nettype wire

// ===== rtl/hms_timer.sv =====
// ----------------------------------------------------------------------------
// hms_timer
// Time checks: minimum hold in avoidance, cooldown state, and the saturated
// cooldown end for a return to baseline.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_timer (
    input  wire logic [31:0]     i_now,
    input  wire logic [31:0]     i_entered,
    input  wire logic [31:0]     i_cool_end,
    input  wire logic [23:0]     i_min_hold,
    input  wire logic [23:0]     i_cool_ms,
    output hms_pkg::t_time_st    o_st
);

    logic [32:0] diff;
    logic [32:0] sum;

    assign diff = {1'b0, i_now} - {1'b0, i_entered};
    assign sum  = {1'b0, i_now} + 33'(i_cool_ms);

    // a time earlier than the entry never meets the hold
    assign o_st.hold_met     = (i_entered == '0) ||
                               (!diff[32] && (diff[31:0] >= 32'(i_min_hold)));
    assign o_st.cool_over    = (i_cool_end == '0) || (i_now >= i_cool_end);
    assign o_st.cool_end_nxt = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

endmodule

`default_nettype wire

// ===== rtl/hysteretic_mode_selector_core.sv =====
// An accepted input beat goes to the input register, its result to the result register.
// Throughput: one beat per cycle while the receiver does not stall the output; the mode
// state updates in a single pass from the input register to the result register.
// Reset (synchronous, active low) restores registers 5, 3, 5, 2000, 1000,
// baseline mode, empty vote window and unset timestamps; no clearing pass.
// ----------------------------------------------------------------------------
// hysteretic_mode_selector_core
// Two-mode selector with k-of-n entry vote, hysteretic exit and cooldown.
// ----------------------------------------------------------------------------
`default_nettype none

module hysteretic_mode_selector_core #(
    parameter int WINDOW_MAX = hms_pkg::WINDOW_MAX_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [hms_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [hms_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [39:0]                     i_s_tdata,  // obstacle_seen, goal_close, now_ms
    input  wire logic [2:0]                      i_s_tuser,  // func
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic [7:0]                           o_m_tdata   // switched, mode_now
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);

    logic [5:0]  r_win_cfg;
    logic [5:0]  r_req;
    logic [15:0] r_exit;
    logic [23:0] r_min_hold;
    logic [23:0] r_cool_ms;

    logic           r_in_vld;
    hms_pkg::t_func r_func;
    logic           r_obst;
    logic           r_goal;
    logic [31:0]    r_now;

    logic                  r_mode,     n_mode;
    logic [WINDOW_MAX-1:0] r_hist,     n_hist;
    logic [FILL_W-1:0]     r_fill,     n_fill;
    logic [15:0]           r_clr,      n_clr;
    logic [31:0]           r_entered,  n_entered;
    logic [31:0]           r_cool_end, n_cool_end;

    logic r_out_vld;
    logic r_sw,       n_sw;
    logic r_mode_out;

    logic                  advance;
    logic [WINDOW_MAX-1:0] hist_nxt;
    logic [FILL_W-1:0]     fill_nxt;
    logic                  vote_pass;
    hms_pkg::t_time_st     tst;
    logic [15:0]           clr_nxt;
    logic                  req_enter;
    logic                  req_base;

    assign advance    = !r_out_vld || i_m_tready;
    assign o_s_tready = !r_in_vld || advance;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {6'b0, r_mode_out, r_sw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_cfg  <= hms_pkg::RST_WINDOW_FRAMES;
            r_req      <= hms_pkg::RST_REQUIRED_FRAMES;
            r_exit     <= hms_pkg::RST_EXIT_CLEAR_FRAMES;
            r_min_hold <= hms_pkg::RST_MIN_HOLD_MS;
            r_cool_ms  <= hms_pkg::RST_COOLDOWN_MS;
        end else if (i_cfg_we) begin
            unique case (hms_pkg::t_cfg_idx'(i_cfg_idx))
                hms_pkg::CFG_WINDOW_FRAMES:     r_win_cfg  <= i_cfg_data[5:0];
                hms_pkg::CFG_REQUIRED_FRAMES:   r_req      <= i_cfg_data[5:0];
                hms_pkg::CFG_EXIT_CLEAR_FRAMES: r_exit     <= i_cfg_data[15:0];
                hms_pkg::CFG_MIN_HOLD_MS:       r_min_hold <= i_cfg_data[23:0];
                hms_pkg::CFG_COOLDOWN_MS:       r_cool_ms  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_in_vld <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_func <= hms_pkg::t_func'(i_s_tuser);
            r_obst <= i_s_tdata[0];
            r_goal <= i_s_tdata[1];
            r_now  <= i_s_tdata[33:2];
        end
    end

    hms_vote #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_vote (
        .i_hist     (r_hist),
        .i_fill     (r_fill),
        .i_win_cfg  (r_win_cfg),
        .i_req      (r_req),
        .i_obst     (r_obst),
        .o_hist_nxt (hist_nxt),
        .o_fill_nxt (fill_nxt),
        .o_pass     (vote_pass)
    );

    hms_timer u_timer (
        .i_now      (r_now),
        .i_entered  (r_entered),
        .i_cool_end (r_cool_end),
        .i_min_hold (r_min_hold),
        .i_cool_ms  (r_cool_ms),
        .o_st       (tst)
    );

    assign clr_nxt = r_obst ? 16'd0 : ((r_clr != 16'hFFFF) ? r_clr + 16'd1 : r_clr);

    always_comb begin
        n_mode     = r_mode;
        n_hist     = r_hist;
        n_fill     = r_fill;
        n_clr      = r_clr;
        n_entered  = r_entered;
        n_cool_end = r_cool_end;
        n_sw       = 1'b0;
        req_enter  = 1'b0;
        req_base   = 1'b0;

        unique case (r_func)
            hms_pkg::FUNC_EVIDENCE: begin
                if (r_goal) begin
                    n_hist   = '0;
                    n_fill   = '0;
                    n_clr    = '0;
                    req_base = 1'b1;
                end else if (!r_mode) begin
                    n_hist    = hist_nxt;
                    n_fill    = fill_nxt;
                    req_enter = vote_pass && tst.cool_over;
                end else begin
                    n_clr    = clr_nxt;
                    req_base = tst.hold_met && (clr_nxt >= r_exit);
                end
            end
            hms_pkg::FUNC_GUARDED:  req_enter = tst.cool_over;
            hms_pkg::FUNC_FORCED:   req_enter = 1'b1;
            hms_pkg::FUNC_FALLBACK: req_base  = 1'b1;
            hms_pkg::FUNC_RESTART: begin
                n_sw       = r_mode;
                n_mode     = 1'b0;
                n_hist     = '0;
                n_fill     = '0;
                n_clr      = '0;
                n_entered  = '0;
                n_cool_end = r_now;
            end
            default: ;
        endcase

        // any mode change clears the vote state and stamps the time
        if (req_enter && !r_mode) begin
            n_sw      = 1'b1;
            n_mode    = 1'b1;
            n_hist    = '0;
            n_fill    = '0;
            n_clr     = '0;
            n_entered = r_now;
        end else if (req_base && r_mode) begin
            n_sw       = 1'b1;
            n_mode     = 1'b0;
            n_hist     = '0;
            n_fill     = '0;
            n_clr      = '0;
            n_cool_end = tst.cool_end_nxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_hist     <= '0;
            r_fill     <= '0;
            r_clr      <= '0;
            r_entered  <= '0;
            r_cool_end <= '0;
        end else if (r_in_vld && advance) begin
            r_mode     <= n_mode;
            r_hist     <= n_hist;
            r_fill     <= n_fill;
            r_clr      <= n_clr;
            r_entered  <= n_entered;
            r_cool_end <= n_cool_end;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld && advance) begin
            r_sw       <= n_sw;
            r_mode_out <= n_mode;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/hms_checker.sv =====
// ----------------------------------------------------------------------------
// hms_checker
// Port-level checks of the mode selector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module hms_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_s_tvalid,
    input wire logic                            o_s_tready,
    input wire logic                            o_m_tvalid,
    input wire logic                            i_m_tready,
    input wire logic [7:0]                      o_m_tdata
);

    logic       r_prev_mode;
    logic [1:0] r_outst;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_s_tvalid && o_s_tready;
    assign out_acc = o_m_tvalid && i_m_tready;

    // track beats in flight and the mode of the last result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_mode <= 1'b0;
            r_outst     <= '0;
        end else begin
            r_outst <= r_outst + 2'(in_acc) - 2'(out_acc);
            if (out_acc) begin
                r_prev_mode <= o_m_tdata[1];
            end
        end
    end

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_outst <= 2'd2) && (!o_m_tvalid || (r_outst != 2'd0)))
        else $error("result count does not match accepted inputs");

    a_switch_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (o_m_tdata[0] == (o_m_tdata[1] != r_prev_mode)))
        else $error("switched flag disagrees with mode change");

endmodule

bind hysteretic_mode_selector_core hms_checker u_hms_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

// ===== tb/sv/tb_hysteretic_mode_selector_core.sv =====
// ----------------------------------------------------------------------------
// tb_hysteretic_mode_selector_core
// Self-checking bench for the two-mode selector. Command beats go in over the
// slave stream and a behavioral predictor of the entry vote, the clear-frame
// exit, the hold time and the cooldown computes each result. Result beats are
// compared in order. Random idling, a long receiver hold-off and register
// changes between phases exercise the handshakes and the configuration.
// ----------------------------------------------------------------------------
module tb_hysteretic_mode_selector_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF_NS  = 6;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 6;
    localparam int WIN_MAX      = hms_pkg::WINDOW_MAX_DEF;
    localparam int EXP_DEPTH    = 16;

    localparam logic [2:0] FUNC_RSVD_FIRST = 3'd5;
    localparam logic [2:0] FUNC_RSVD_MID   = 3'd6;
    localparam logic [2:0] FUNC_RSVD_LAST  = 3'd7;

    localparam logic [hms_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic switched;
        logic mode_now;
    } t_mode_result;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           cfg_we   = 1'b0;
    logic [hms_pkg::CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [hms_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [39:0]                    s_tdata  = '0;   // obstacle_seen, goal_close, now_ms
    logic [2:0]                     s_tuser  = '0;   // func
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [7:0]                     m_tdata;         // switched, mode_now

    // predictor copy of the registers
    logic [5:0]  reg_window     = hms_pkg::RST_WINDOW_FRAMES;
    logic [5:0]  reg_required   = hms_pkg::RST_REQUIRED_FRAMES;
    logic [15:0] reg_exit_clear = hms_pkg::RST_EXIT_CLEAR_FRAMES;
    logic [23:0] reg_min_hold   = hms_pkg::RST_MIN_HOLD_MS;
    logic [23:0] reg_cooldown   = hms_pkg::RST_COOLDOWN_MS;

    // predictor copy of the mode state
    logic        mode_avoid  = 1'b0;
    logic [63:0] vote_bits   = '0;
    int unsigned vote_fill   = 0;
    logic [15:0] clear_run   = '0;
    logic [31:0] entered_ms  = '0;
    logic [31:0] cool_end_ms = '0;

    // ring of expected results, written at input accept, read at result accept
    t_mode_result expected_modes[EXP_DEPTH];
    int           exp_wr = 0;
    int           exp_rd = 0;

    int src_idle_pct   = 0;
    int sink_idle_pct  = 0;
    int sink_hold_left = 0;
    int idle_cycles    = 0;
    int n_items        = 0;
    int n_results      = 0;
    int n_switches     = 0;
    int n_cfg_writes   = 0;
    int n_errors       = 0;

    hysteretic_mode_selector_core dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    initial begin
        forever #(CLK_HALF_NS) clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Mode predictor
    // ------------------------------------------------------------------------
    function automatic bit cooldown_done(input logic [31:0] now);
        return (cool_end_ms == 32'd0) || (now >= cool_end_ms);
    endfunction

    task automatic clear_votes();
        vote_bits = '0;
        vote_fill = 0;
        clear_run = '0;
    endtask

    task automatic switch_mode(input logic target, input logic [31:0] now, output logic sw);
        logic [32:0] end_sum;
        sw = 1'b0;
        if (mode_avoid != target) begin
            sw         = 1'b1;
            mode_avoid = target;
            clear_votes();
            if (target) begin
                entered_ms = now;
            end else begin
                // saturate the cooldown end at the largest timestamp
                end_sum     = {1'b0, now} + {9'd0, reg_cooldown};
                cool_end_ms = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
            end
        end
    endtask

    task automatic select_mode(input logic [2:0] func, input logic obs, input logic goal,
                               input logic [31:0] now, output t_mode_result res);
        int unsigned win;
        logic [63:0] mask;
        logic        held;
        logic        sw;
        sw = 1'b0;
        case (func)
            hms_pkg::FUNC_EVIDENCE: begin
                if (goal) begin
                    clear_votes();
                    switch_mode(1'b0, now, sw);
                end else if (!mode_avoid) begin
                    win = reg_window;
                    if (win < 1) win = 1;
                    if (win > WIN_MAX) win = WIN_MAX;
                    mask      = (64'd1 << win) - 64'd1;
                    vote_bits = ((vote_bits << 1) | {63'd0, obs}) & mask;
                    vote_fill = (vote_fill + 1 > win) ? win : vote_fill + 1;
                    if (vote_fill == win && $countones(vote_bits) >= reg_required &&
                        cooldown_done(now))
                        switch_mode(1'b1, now, sw);
                end else begin
                    if (obs) clear_run = '0;
                    else if (clear_run != 16'hFFFF) clear_run = clear_run + 16'd1;
                    held = (entered_ms == 32'd0) ||
                           (now >= entered_ms && (now - entered_ms) >= {8'd0, reg_min_hold});
                    if (held && clear_run >= reg_exit_clear)
                        switch_mode(1'b0, now, sw);
                end
            end
            hms_pkg::FUNC_GUARDED: begin
                if (cooldown_done(now)) switch_mode(1'b1, now, sw);
            end
            hms_pkg::FUNC_FORCED:   switch_mode(1'b1, now, sw);
            hms_pkg::FUNC_FALLBACK: switch_mode(1'b0, now, sw);
            hms_pkg::FUNC_RESTART: begin
                sw          = mode_avoid;
                mode_avoid  = 1'b0;
                clear_votes();
                entered_ms  = '0;
                cool_end_ms = now;
            end
            default: ;
        endcase
        res.switched = sw;
        res.mode_now = mode_avoid;
    endtask

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    task automatic send_item(input logic [2:0] func, input logic obs, input logic goal,
                             input logic [31:0] now);
        t_mode_result res;
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'd0, now, goal, obs};
        do @(posedge clk); while (!s_tready);
        select_mode(func, obs, goal, now, res);
        expected_modes[exp_wr % EXP_DEPTH] = res;
        exp_wr++;
        n_items++;
    endtask

    // drop valid and hold until every expected result has come back
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [hms_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hms_pkg::CFG_DATA_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            hms_pkg::CFG_WINDOW_FRAMES:     reg_window     = value[5:0];
            hms_pkg::CFG_REQUIRED_FRAMES:   reg_required   = value[5:0];
            hms_pkg::CFG_EXIT_CLEAR_FRAMES: reg_exit_clear = value[15:0];
            hms_pkg::CFG_MIN_HOLD_MS:       reg_min_hold   = value;
            hms_pkg::CFG_COOLDOWN_MS:       reg_cooldown   = value;
            default: ;
        endcase
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------------
    // Receiver, result checker and watchdog
    // ------------------------------------------------------------------------
    always @(negedge clk) begin
        if (sink_hold_left > 0) begin
            m_tready <= 1'b0;
            sink_hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk) begin : check_result
        t_mode_result exp_res;
        if (rst_n && m_tvalid && m_tready) begin
            n_results++;
            if (exp_wr == exp_rd) begin
                $error("result beat 0x%02h with no expectation pending", m_tdata);
                n_errors++;
            end else begin
                exp_res = expected_modes[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_tdata[0] !== exp_res.switched) begin
                    $error("switched: expected %0d, got %0d", exp_res.switched, m_tdata[0]);
                    n_errors++;
                end
                if (m_tdata[1] !== exp_res.mode_now) begin
                    $error("mode_now: expected %0d, got %0d", exp_res.mode_now, m_tdata[1]);
                    n_errors++;
                end
                if (exp_res.switched) n_switches++;
            end
        end
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed_commands();
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        send_item(FUNC_RSVD_FIRST,        1'b1, 1'b1, 32'd0);
        send_item(hms_pkg::FUNC_FALLBACK, 1'b0, 1'b0, 32'd10);
        // fill the default window, entry on the fifth frame
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b0, 32'd100);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b0, 32'd200);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd300);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b0, 32'd400);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b0, 32'd500);
        send_item(hms_pkg::FUNC_FORCED,   1'b0, 1'b0, 32'd600);
        // time before entry never meets the hold
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd400);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd2400);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd2500);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd2600);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd2700);
        send_item(hms_pkg::FUNC_GUARDED,  1'b0, 1'b0, 32'd3000);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b1, 32'd3100);
        send_item(hms_pkg::FUNC_GUARDED,  1'b0, 1'b0, 32'd3700);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b1, 32'd3800);
        send_item(hms_pkg::FUNC_RESTART,  1'b0, 1'b0, 32'd3900);
        // entry at time zero leaves the entry time unset
        send_item(hms_pkg::FUNC_FORCED,   1'b1, 1'b0, 32'd0);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(hms_pkg::FUNC_RESTART,  1'b1, 1'b1, 32'hFFFF_FFFF);
        send_item(hms_pkg::FUNC_GUARDED,  1'b0, 1'b0, 32'hFFFF_FFFE);
        send_item(hms_pkg::FUNC_GUARDED,  1'b0, 1'b0, 32'hFFFF_FFFF);
        send_item(FUNC_RSVD_MID,  1'b0, 1'b1, 32'hAAAA_5555);
        send_item(FUNC_RSVD_LAST, 1'b1, 1'b0, 32'h5555_AAAA);
    endtask

    task automatic test_register_extremes();
        src_idle_pct  = 10;
        sink_idle_pct = 10;
        // zero window acts as one, zero requirement always passes
        write_reg(hms_pkg::CFG_WINDOW_FRAMES, 24'd0);
        write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'd0);
        write_reg(hms_pkg::CFG_EXIT_CLEAR_FRAMES, 24'd0);
        write_reg(hms_pkg::CFG_MIN_HOLD_MS, 24'd0);
        send_item(hms_pkg::FUNC_RESTART,  1'b0, 1'b0, 32'd0);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'd50);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b0, 32'd60);
        // saturated cooldown end
        write_reg(hms_pkg::CFG_COOLDOWN_MS, 24'hFF_FFFF);
        send_item(hms_pkg::FUNC_FORCED,   1'b0, 1'b0, 32'hF000_0000);
        send_item(hms_pkg::FUNC_FALLBACK, 1'b0, 1'b0, 32'hFFFF_0000);
        send_item(hms_pkg::FUNC_GUARDED,  1'b0, 1'b0, 32'hFFFF_FFFE);
        // oversized window clamps, requirement above window never passes
        write_reg(hms_pkg::CFG_WINDOW_FRAMES, 24'd63);
        write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'd63);
        write_reg(hms_pkg::CFG_EXIT_CLEAR_FRAMES, 24'd65535);
        write_reg(hms_pkg::CFG_MIN_HOLD_MS, 24'hFF_FFFF);
        write_reg(CFG_UNUSED, 24'hFF_FFFF);
        send_item(hms_pkg::FUNC_RESTART,  1'b1, 1'b0, 32'd5);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b1, 1'b0, 32'd6);
        send_item(hms_pkg::FUNC_FORCED,   1'b0, 1'b0, 32'd7);
        send_item(hms_pkg::FUNC_EVIDENCE, 1'b0, 1'b0, 32'hFFFF_FFFF);
        // upper data bits beyond the register width are dropped
        write_reg(hms_pkg::CFG_WINDOW_FRAMES, 24'hABCD_C5);
        write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'h5432_C2);
        send_item(hms_pkg::FUNC_FALLBACK, 1'b0, 1'b0, 32'd8);
    endtask

    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        write_reg(hms_pkg::CFG_COOLDOWN_MS, 24'd100);
        write_reg(hms_pkg::CFG_MIN_HOLD_MS, 24'd50);
        write_reg(hms_pkg::CFG_EXIT_CLEAR_FRAMES, 24'd2);
        sink_hold_left = 80;
        for (int k = 0; k < 40; k++)
            send_item(hms_pkg::FUNC_EVIDENCE, k[1], 1'b0, 32'(1000 + 30 * k));
        settle();
        for (int k = 0; k < 10; k++)
            send_item(3'($urandom_range(hms_pkg::FUNC_RESTART, hms_pkg::FUNC_EVIDENCE)),
                      k[0], 1'b0, 32'(3000 + 40 * k));
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int count);
        logic [31:0] sim_ms;
        logic [2:0]  func;
        logic [31:0] now;
        int          roll;
        int          win;
        int          obs_pct;
        sim_ms = 32'($urandom_range(1000, 1));
        for (int k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(9))
                    0:       win = 0;
                    1:       win = 32;
                    2:       win = 63;
                    3:       win = $urandom_range(62, 33);
                    default: win = $urandom_range(8, 1);
                endcase
                write_reg(hms_pkg::CFG_WINDOW_FRAMES, 24'(win));
                if (win < 1) win = 1;
                if (win > WIN_MAX) win = WIN_MAX;
                case ($urandom_range(7))
                    0: write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'd0);
                    1: write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'(win + 1));
                    2: write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'd63);
                    default:
                        write_reg(hms_pkg::CFG_REQUIRED_FRAMES, 24'($urandom_range(win, 1)));
                endcase
                case ($urandom_range(7))
                    0: write_reg(hms_pkg::CFG_EXIT_CLEAR_FRAMES, 24'd0);
                    1: write_reg(hms_pkg::CFG_EXIT_CLEAR_FRAMES, 24'd65535);
                    default:
                        write_reg(hms_pkg::CFG_EXIT_CLEAR_FRAMES, 24'($urandom_range(6, 1)));
                endcase
                case ($urandom_range(7))
                    0:       write_reg(hms_pkg::CFG_MIN_HOLD_MS, 24'd0);
                    1:       write_reg(hms_pkg::CFG_MIN_HOLD_MS, 24'hFF_FFFF);
                    default: write_reg(hms_pkg::CFG_MIN_HOLD_MS, 24'($urandom_range(400)));
                endcase
                case ($urandom_range(7))
                    0:       write_reg(hms_pkg::CFG_COOLDOWN_MS, 24'd0);
                    1:       write_reg(hms_pkg::CFG_COOLDOWN_MS, 24'hFF_FFFF);
                    default: write_reg(hms_pkg::CFG_COOLDOWN_MS, 24'($urandom_range(400)));
                endcase
                // some chunks run without idling on either side
                if ($urandom_range(3) == 0) begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end else begin
                    src_idle_pct  = src_pct;
                    sink_idle_pct = sink_pct;
                end
            end
            if ($urandom_range(199) == 0) sim_ms = $urandom;
            sim_ms  = sim_ms + 32'($urandom_range(120));
            now     = sim_ms;
            // alternate runs of dense and sparse obstacle evidence
            obs_pct = ((k / 8) % 2 == 0) ? 85 : 10;
            roll    = $urandom_range(99);
            if (roll < 80) begin
                send_item(hms_pkg::FUNC_EVIDENCE, $urandom_range(99) < obs_pct,
                          $urandom_range(49) == 0, now);
            end else if (roll < 94) begin
                func = 3'($urandom_range(hms_pkg::FUNC_RESTART, hms_pkg::FUNC_GUARDED));
                send_item(func, 1'($urandom), 1'($urandom), now);
            end else begin
                case ($urandom_range(3))
                    0:       now = $urandom;
                    1:       now = 32'd0;
                    2:       now = 32'hFFFF_FFFF;
                    default: now = sim_ms - 32'($urandom_range(3000));
                endcase
                send_item(3'($urandom_range(FUNC_RSVD_LAST)), 1'($urandom), 1'($urandom), now);
            end
        end
    endtask

    initial begin
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_directed_commands();
        test_register_extremes();
        test_backpressure();
        test_random_traffic(34, 81, 225);
        test_random_traffic(81, 34, 225);
        test_random_traffic(0, 0, 225);
        settle();
        if (exp_wr != exp_rd) begin
            $error("%0d expected results never arrived", exp_wr - exp_rd);
            n_errors++;
        end
        $display("Run covered %0d command beats, %0d result beats and %0d mode switches,",
                 n_items, n_results, n_switches);
        $display("with %0d register writes, random idling on both sides and a long hold-off.",
                 n_cfg_writes);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hms_pkg.sv
rtl/hms_vote.sv
rtl/hms_timer.sv
rtl/hysteretic_mode_selector_core.sv
rtl/hms_checker.sv
tb/sv/tb_hysteretic_mode_selector_core.sv
